// File: sv/jse_pkg.sv
// Package for the JSON string escaper: payload structs, the command passed
// from the front to the back through the queue, state encodings and constants.
// No dependencies.
`default_nettype none

package jse_pkg;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_string;
        logic       last_of_string;
        logic       no_byte;
    } t_in;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       bad_sequence;
    } t_out;

    // Body of one command: nothing, one literal character, a two-character
    // escape, one \uXXXX unit, or a surrogate pair of two units.
    typedef enum logic [2:0] {
        K_NONE,
        K_CHAR,
        K_ESC,
        K_U1,
        K_U2
    } t_kind;

    typedef struct packed {
        logic        open_q;
        logic        close_q;
        t_kind       kind;
        logic [7:0]  chr;
        logic [15:0] unit_a;
        logic [15:0] unit_b;
        logic        bad;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_OPEN,
        B_BODY,
        B_CLOSE
    } t_bstate;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Body step counter covers the longest body, a surrogate pair.
    localparam int UNIT_CHARS = 6;
    localparam int BODY_MAX   = 2 * UNIT_CHARS;
    localparam int BCW        = $clog2(BODY_MAX);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h57 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/jse_front.sv
// Front end of the JSON string escaper: accepts input transactions, runs the
// UTF-8 decoder and turns each item into at most one command for the back end.
// Depends on jse_pkg.
`default_nettype none

module jse_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_data,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire jse_pkg::t_in   i_data,
    input  wire logic           i_q_full,
    output logic                o_push,
    output jse_pkg::t_cmd       o_cmd
);

    logic        r_mode;
    logic [20:0] r_acc;
    logic [1:0]  r_rem;
    logic        r_held;

    logic [20:0] n_acc;
    logic [1:0]  n_rem;
    logic        n_held;

    logic        accept;
    logic        bad;
    logic        handled;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  b;
    logic [20:0] w_cp;
    logic [19:0] w_v;
    logic [20:0] w_diff;
    jse_pkg::t_cmd cmd;

    assign b       = i_data.in_byte;
    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign w_cp    = {r_acc[14:0], b[5:0]};
    assign w_diff  = w_cp - 21'h010000;
    assign w_v     = w_diff[19:0];

    always_comb begin
        n_acc   = r_acc;
        n_rem   = r_rem;
        bad     = 1'b0;
        handled = 1'b0;
        lo      = 8'h80;
        hi      = 8'hBF;
        cmd.open_q  = i_data.first_of_string;
        cmd.close_q = i_data.last_of_string;
        cmd.kind    = jse_pkg::K_NONE;
        cmd.chr     = b;
        cmd.unit_a  = {8'h00, b};
        cmd.unit_b  = 16'h0000;

        // A new string ends whatever sequence was left open.
        if (i_data.first_of_string) begin
            if (n_rem != 2'd0) bad = 1'b1;
            n_rem = 2'd0;
            n_acc = '0;
        end

        if (!i_data.no_byte) begin
            if (r_mode && n_rem != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    handled = 1'b1;
                    if (n_rem == 2'd3) begin
                        if (n_acc == 21'd0) lo = 8'h90;
                        if (n_acc == 21'd4) hi = 8'h8F;
                    end else if (n_rem == 2'd2 && n_acc < 21'h10) begin
                        if (n_acc == 21'd0) lo = 8'hA0;
                        if (n_acc == 21'hD) hi = 8'h9F;
                    end
                    if (b < lo || b > hi) begin
                        bad   = 1'b1;
                        n_rem = 2'd0;
                        n_acc = '0;
                    end else if (n_rem == 2'd1) begin
                        n_rem = 2'd0;
                        n_acc = '0;
                        if (w_cp < 21'h010000) begin
                            cmd.kind   = jse_pkg::K_U1;
                            cmd.unit_a = w_cp[15:0];
                        end else begin
                            cmd.kind   = jse_pkg::K_U2;
                            cmd.unit_a = {6'b110110, w_v[19:10]};
                            cmd.unit_b = {6'b110111, w_v[9:0]};
                        end
                    end else begin
                        n_rem = n_rem - 2'd1;
                        n_acc = w_cp;
                    end
                end else begin
                    // Interrupted sequence: drop it, then treat this byte as new.
                    bad   = 1'b1;
                    n_rem = 2'd0;
                    n_acc = '0;
                end
            end else if (!r_mode) begin
                if (n_rem != 2'd0) bad = 1'b1;
                n_rem = 2'd0;
                n_acc = '0;
            end

            if (!handled) begin
                if (b < 8'h80 || !r_mode) begin
                    case (b)
                        jse_pkg::CH_QUOTE, jse_pkg::CH_BSL: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.chr  = b;
                        end
                        8'h08: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.chr  = jse_pkg::CH_B;
                        end
                        8'h0C: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.chr  = jse_pkg::CH_F;
                        end
                        8'h0A: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.chr  = jse_pkg::CH_N;
                        end
                        8'h0D: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.chr  = jse_pkg::CH_R;
                        end
                        8'h09: begin
                            cmd.kind = jse_pkg::K_ESC;
                            cmd.chr  = jse_pkg::CH_T;
                        end
                        default: begin
                            if (b < jse_pkg::CTRL_LIMIT) begin
                                cmd.kind = jse_pkg::K_U1;
                            end else begin
                                cmd.kind = jse_pkg::K_CHAR;
                            end
                        end
                    endcase
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    n_acc = {16'h0, b[4:0]};
                    n_rem = 2'd1;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    n_acc = {17'h0, b[3:0]};
                    n_rem = 2'd2;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    n_acc = {18'h0, b[2:0]};
                    n_rem = 2'd3;
                end else begin
                    bad = 1'b1;
                end
            end
        end

        if (i_data.last_of_string) begin
            if (n_rem != 2'd0) bad = 1'b1;
            n_rem = 2'd0;
            n_acc = '0;
        end

        o_push  = accept && (i_data.first_of_string || i_data.last_of_string ||
                             cmd.kind != jse_pkg::K_NONE);
        cmd.bad = r_held || bad;
        // A drop on an item with no output is reported with the next output.
        n_held  = o_push ? 1'b0 : (r_held || bad);
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_acc  <= '0;
            r_rem  <= 2'd0;
            r_held <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (accept) begin
                r_acc  <= n_acc;
                r_rem  <= n_rem;
                r_held <= n_held;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/jse_queue.sv
// Short command queue between the front and back ends of the escaper.
// Depends on jse_pkg.
`default_nettype none

module jse_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire jse_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output jse_pkg::t_cmd       o_cmd
);

    jse_pkg::t_cmd r_mem [jse_pkg::Q_DEPTH];

    logic [jse_pkg::Q_AW-1:0] r_wp;
    logic [jse_pkg::Q_AW-1:0] r_rp;
    logic [jse_pkg::Q_CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == jse_pkg::Q_CW'(jse_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [jse_pkg::Q_AW-1:0] bump(input logic [jse_pkg::Q_AW-1:0] p);
        logic [jse_pkg::Q_AW-1:0] q;
        if (p == jse_pkg::Q_AW'(jse_pkg::Q_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= bump(r_wp);
            if (do_pop)  r_rp <= bump(r_rp);
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/jse_back.sv
// Back end of the escaper: expands each queued command into output
// characters, one per cycle while not stalled, through a registered output stage.
// Depends on jse_pkg.
`default_nettype none

module jse_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire jse_pkg::t_cmd  i_q_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output jse_pkg::t_out       o_data
);

    jse_pkg::t_bstate          r_state;
    jse_pkg::t_cmd             r_cmd;
    logic [jse_pkg::BCW-1:0]   r_cnt;
    logic                      r_out_valid;
    jse_pkg::t_out             r_out;

    jse_pkg::t_bstate          n_state;
    jse_pkg::t_cmd             n_cmd;
    logic [jse_pkg::BCW-1:0]   n_cnt;

    logic                      can_emit;
    logic                      advance;
    logic                      is_final;
    logic                      body_end;
    logic [jse_pkg::BCW-1:0]   body_last;
    logic [jse_pkg::BCW-1:0]   kk;
    logic [15:0]               unit;
    logic [7:0]                cur_byte;
    jse_pkg::t_bstate          start_state;

    assign can_emit = !r_out_valid || !i_stall;
    assign advance  = (r_state != jse_pkg::B_IDLE) && can_emit;

    // First phase of the command at the queue head.
    always_comb begin
        if (i_q_cmd.open_q) begin
            start_state = jse_pkg::B_OPEN;
        end else if (i_q_cmd.kind != jse_pkg::K_NONE) begin
            start_state = jse_pkg::B_BODY;
        end else begin
            start_state = jse_pkg::B_CLOSE;
        end
    end

    // Output and step decode for the current command.
    always_comb begin
        case (r_cmd.kind)
            jse_pkg::K_ESC:  body_last = jse_pkg::BCW'(1);
            jse_pkg::K_U1:   body_last = jse_pkg::BCW'(jse_pkg::UNIT_CHARS - 1);
            jse_pkg::K_U2:   body_last = jse_pkg::BCW'(jse_pkg::BODY_MAX - 1);
            default:         body_last = '0;
        endcase
        body_end = (r_cnt == body_last);

        if (r_cnt >= jse_pkg::BCW'(jse_pkg::UNIT_CHARS)) begin
            kk   = r_cnt - jse_pkg::BCW'(jse_pkg::UNIT_CHARS);
            unit = r_cmd.unit_b;
        end else begin
            kk   = r_cnt;
            unit = r_cmd.unit_a;
        end

        cur_byte = r_cmd.chr;
        is_final = 1'b0;
        case (r_state)
            jse_pkg::B_OPEN: begin
                cur_byte = jse_pkg::CH_QUOTE;
                is_final = (r_cmd.kind == jse_pkg::K_NONE) && !r_cmd.close_q;
            end
            jse_pkg::B_BODY: begin
                is_final = body_end && !r_cmd.close_q;
                case (r_cmd.kind)
                    jse_pkg::K_ESC: begin
                        cur_byte = (r_cnt == '0) ? jse_pkg::CH_BSL : r_cmd.chr;
                    end
                    jse_pkg::K_U1, jse_pkg::K_U2: begin
                        case (kk)
                            jse_pkg::BCW'(0): cur_byte = jse_pkg::CH_BSL;
                            jse_pkg::BCW'(1): cur_byte = jse_pkg::CH_U;
                            jse_pkg::BCW'(2): cur_byte = jse_pkg::hex_char(unit[15:12]);
                            jse_pkg::BCW'(3): cur_byte = jse_pkg::hex_char(unit[11:8]);
                            jse_pkg::BCW'(4): cur_byte = jse_pkg::hex_char(unit[7:4]);
                            default:          cur_byte = jse_pkg::hex_char(unit[3:0]);
                        endcase
                    end
                    default: cur_byte = r_cmd.chr;
                endcase
            end
            jse_pkg::B_CLOSE: begin
                cur_byte = jse_pkg::CH_QUOTE;
                is_final = 1'b1;
            end
            default: begin
                cur_byte = r_cmd.chr;
                is_final = 1'b0;
            end
        endcase

        // The next command is taken in the same cycle the current one ends.
        o_pop = i_q_valid && ((r_state == jse_pkg::B_IDLE) || (advance && is_final));
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        case (r_state)
            jse_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    n_state = start_state;
                    n_cmd   = i_q_cmd;
                    n_cnt   = '0;
                end
            end
            jse_pkg::B_OPEN, jse_pkg::B_BODY, jse_pkg::B_CLOSE: begin
                if (advance) begin
                    if (is_final) begin
                        if (i_q_valid) begin
                            n_state = start_state;
                            n_cmd   = i_q_cmd;
                            n_cnt   = '0;
                        end else begin
                            n_state = jse_pkg::B_IDLE;
                        end
                    end else if (r_state == jse_pkg::B_OPEN) begin
                        n_state = (r_cmd.kind != jse_pkg::K_NONE) ? jse_pkg::B_BODY
                                                                  : jse_pkg::B_CLOSE;
                        n_cnt   = '0;
                    end else if (body_end) begin
                        n_state = jse_pkg::B_CLOSE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: n_state = jse_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jse_pkg::B_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (advance) begin
            r_out.out_byte     <= cur_byte;
            r_out.last_of_run  <= is_final;
            r_out.bad_sequence <= r_cmd.bad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// File: sv/json_string_escaper.sv
// Top level of the JSON string escaper: front end, command queue, back end.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
`default_nettype none

// Turns a byte stream into quoted JSON string text, one output character per
// transaction. The front end accepts one input byte per cycle while the
// four-entry command queue has room; the back end emits exactly one character
// per cycle while the output is not stalled, with no gap between items that
// are already queued. An item yields the characters of its escaped form:
// 1 for a plain byte, 2 for a short escape, 6 for a \u unit, 12 for a
// surrogate pair, plus one for each quote, and none for a byte that just
// continues an open UTF-8 sequence. With an idle output, the first character
// of an accepted byte passes through the command queue, the back end's command
// register and its registered output stage before it is presented. Write the
// ascii-only mode bit only while no transaction is in flight.
module json_string_escaper (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_data,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire jse_pkg::t_in   i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output jse_pkg::t_out       o_data
);

    logic          q_full;
    logic          push;
    logic          pop;
    logic          q_valid;
    jse_pkg::t_cmd push_cmd;
    jse_pkg::t_cmd head_cmd;

    jse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

`default_nettype wire
